/* hw/rtl/cbff_pkg.sv */
// Shared types and constants for the counter-based flood duplicate filter.
package cbff_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_ORIGINATE = 2'd0;
   localparam logic [1:0] KIND_ARRIVAL   = 2'd1;
   localparam logic [1:0] KIND_FORWARD   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_COUNTER = 2'd0;
   localparam logic [1:0] CSR_OWN_ADDR    = 2'd1;
   localparam logic [1:0] CSR_BCAST_ADDR  = 2'd2;

   // Configuration register reset values.
   localparam logic [7:0]  MAX_COUNTER_RST = 8'd3;
   localparam logic [15:0] OWN_ADDR_RST    = 16'h0000;
   localparam logic [15:0] BCAST_ADDR_RST  = 16'hFFFF;

   // One request.
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] src_addr;
      logic [15:0] seq_num;
      logic [15:0] dst_addr;
      logic [7:0]  hops_in;
   } cbff_req_type;

   // One result.
   typedef struct packed {
      logic        duplicate;
      logic        deliver;
      logic        schedule_forward;
      logic        send_now;
      logic        entry_missing;
      logic [7:0]  hops_out;
      logic [15:0] seq_out;
   } cbff_rsp_type;

   // One history entry.
   typedef struct packed {
      logic [15:0] src;
      logic [15:0] seq;
      logic [7:0]  count;
   } cbff_entry_type;

   // Current configuration.
   typedef struct packed {
      logic [7:0]  max_counter;
      logic [15:0] own_address;
      logic [15:0] broadcast_address;
   } cbff_cfg_type;

endpackage

/* hw/rtl/cbff_hist_mem.sv */
// History memory: one write port and one registered read port.
module cbff_hist_mem
   import cbff_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  cbff_entry_type wr_data,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output cbff_entry_type rd_data
);

   cbff_entry_type mem_ff [DEPTH];
   cbff_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cbff_ctrl.sv */
// Sequencer: walks the history FIFO, then updates it (originate and arrival only) and builds the result.
module cbff_ctrl
   import cbff_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  cbff_req_type   req_data,
   input  cbff_cfg_type   cfg,
   output logic           rsp_valid,
   output cbff_rsp_type   rsp_data,
   output logic           mem_wr_en,
   output logic [AW-1:0]  mem_wr_addr,
   output cbff_entry_type mem_wr_data,
   output logic           mem_rd_en,
   output logic [AW-1:0]  mem_rd_addr,
   input  cbff_entry_type mem_rd_data
);

   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type      state_ff, state_in;
   cbff_req_type   item_ff, item_in;
   logic [15:0]    key_src_ff, key_src_in;
   logic [15:0]    key_seq_ff, key_seq_in;
   logic [15:0]    lseq_ff, lseq_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic           cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]  cmp_slot_ff, cmp_slot_in;
   logic           hit_ff, hit_in;
   logic [AW-1:0]  hit_slot_ff, hit_slot_in;
   logic [7:0]     hit_count_ff, hit_count_in;
   logic [AW-1:0]  oldest_ff, oldest_in;
   logic [CW-1:0]  fill_ff, fill_in;
   logic           rsp_valid_ff, rsp_valid_in;
   cbff_rsp_type   rsp_ff, rsp_in;

   logic [SW-1:0]  scan_sum;
   logic [SW-1:0]  fill_sum;
   logic [SW-1:0]  next_sum;
   logic [AW-1:0]  scan_addr;
   logic [AW-1:0]  tail_addr;
   logic [AW-1:0]  oldest_next;
   logic [15:0]    lseq_next;
   logic           is_insert_kind;

   // Slot addresses: oldest plus an offset, wrapped once around the FIFO.
   always_comb begin
      scan_sum = SW'(oldest_ff) + SW'(scan_ff);
      if (scan_sum >= DEPTH_S) begin
         scan_sum = scan_sum - DEPTH_S;
      end
      fill_sum = SW'(oldest_ff) + SW'(fill_ff);
      if (fill_sum >= DEPTH_S) begin
         fill_sum = fill_sum - DEPTH_S;
      end
      next_sum = SW'(oldest_ff) + SW'(1);
      if (next_sum >= DEPTH_S) begin
         next_sum = next_sum - DEPTH_S;
      end
   end

   assign scan_addr      = scan_sum[AW-1:0];
   assign tail_addr      = fill_sum[AW-1:0];
   assign oldest_next    = next_sum[AW-1:0];
   assign lseq_next      = lseq_ff + 16'd1;
   assign is_insert_kind = (item_ff.kind == KIND_ORIGINATE) ||
                           (item_ff.kind == KIND_ARRIVAL);

   // Next-state logic.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      key_src_in   = key_src_ff;
      key_seq_in   = key_seq_ff;
      lseq_in      = lseq_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_slot_in  = cmp_slot_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_count_in = hit_count_ff;
      oldest_in    = oldest_ff;
      fill_in      = fill_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = hit_slot_ff;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_addr;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in = req_data;
               scan_in = '0;
               hit_in  = 1'b0;
               if (req_data.kind == KIND_ORIGINATE) begin
                  lseq_in    = lseq_next;
                  key_src_in = cfg.own_address;
                  key_seq_in = lseq_next;
               end else begin
                  key_src_in = req_data.src_addr;
                  key_seq_in = req_data.seq_num;
               end
               if (req_data.kind == KIND_ORIGINATE || req_data.kind == KIND_ARRIVAL ||
                   req_data.kind == KIND_FORWARD) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle; compare the entry read last cycle.
            mem_rd_en   = (scan_ff < fill_ff);
            cmp_vld_in  = mem_rd_en;
            cmp_slot_in = scan_addr;
            scan_in     = scan_ff + CW'(mem_rd_en);
            if (cmp_vld_ff && mem_rd_data.src == key_src_ff &&
                mem_rd_data.seq == key_seq_ff) begin
               hit_in       = 1'b1;
               hit_slot_in  = cmp_slot_ff;
               hit_count_in = mem_rd_data.count;
               state_in     = ST_UPDATE;
            end else if (!mem_rd_en && !cmp_vld_ff) begin
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            // For originates and arrivals: counter bump on a hit below the limit, FIFO insert on a miss.
            if (is_insert_kind) begin
               if (hit_ff) begin
                  mem_wr_en   = (hit_count_ff < cfg.max_counter);
                  mem_wr_addr = hit_slot_ff;
                  mem_wr_data = '{src: key_src_ff, seq: key_seq_ff,
                                  count: hit_count_ff + 8'd1};
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = '{src: key_src_ff, seq: key_seq_ff, count: 8'd0};
                  if (fill_ff == DEPTH_C) begin
                     mem_wr_addr = oldest_ff;
                     oldest_in   = oldest_next;
                  end else begin
                     mem_wr_addr = tail_addr;
                     fill_in     = fill_ff + CW'(1);
                  end
               end
            end

            // Result fields by kind.
            rsp_in = '0;
            case (item_ff.kind)
               KIND_ORIGINATE: begin
                  rsp_in.send_now = 1'b1;
                  rsp_in.seq_out  = key_seq_ff;
               end
               KIND_ARRIVAL: begin
                  rsp_in.hops_out = (item_ff.hops_in == 8'hFF) ? 8'hFF :
                                    item_ff.hops_in + 8'd1;
                  if (hit_ff) begin
                     rsp_in.duplicate = 1'b1;
                  end else begin
                     rsp_in.deliver = (item_ff.dst_addr == cfg.own_address) ||
                                      (item_ff.dst_addr == cfg.broadcast_address);
                     rsp_in.schedule_forward = (item_ff.dst_addr != cfg.own_address);
                  end
               end
               KIND_FORWARD: begin
                  if (hit_ff) begin
                     rsp_in.send_now = (hit_count_ff < cfg.max_counter);
                  end else begin
                     rsp_in.entry_missing = 1'b1;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lseq_ff      <= '0;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lseq_ff      <= lseq_in;
         oldest_ff    <= oldest_in;
         fill_ff      <= fill_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      key_src_ff   <= key_src_in;
      key_seq_ff   <= key_seq_in;
      scan_ff      <= scan_in;
      cmp_slot_ff  <= cmp_slot_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_count_ff <= hit_count_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/counter_based_flood_filter_core.sv */
// Top level of the counter-based flood duplicate filter.
// The history FIFO is read one entry a cycle, so a lookup takes longer as the history
// fills; the unused kind skips the scan. One request is handled at a time; a new request
// is taken in the cycle its predecessor's result is shown. The receiver cannot stall.
// Reset empties the history, clears the sequence and restores the register defaults.
module counter_based_flood_filter_core
   import cbff_pkg::*;
#(
   parameter int HISTORY_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  cbff_req_type req_data,
   output logic         rsp_valid,
   output cbff_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = $clog2(HISTORY_DEPTH + 1);

   cbff_cfg_type   cfg_ff, cfg_in;
   logic           mem_wr_en;
   logic [AW-1:0]  mem_wr_addr;
   cbff_entry_type mem_wr_data;
   logic           mem_rd_en;
   logic [AW-1:0]  mem_rd_addr;
   cbff_entry_type mem_rd_data;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_COUNTER: cfg_in.max_counter       = csr_wdata[7:0];
            CSR_OWN_ADDR:    cfg_in.own_address       = csr_wdata;
            CSR_BCAST_ADDR:  cfg_in.broadcast_address = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{max_counter: MAX_COUNTER_RST, own_address: OWN_ADDR_RST,
                     broadcast_address: BCAST_ADDR_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Lookup and update sequencer.
   cbff_ctrl #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // History storage.
   cbff_hist_mem #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_hist_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* hw/rtl/cbff_checker.sv */
// Port-level checks for the flood filter core, bound to the top level.
module cbff_checker
   import cbff_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input cbff_rsp_type rsp_data
);

   // An accepted request keeps the core busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a request");

   // Results are single-cycle strobes and never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result only follows a busy cycle.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

   // A duplicate arrival is neither delivered, forwarded nor sent.
   a_dup_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.duplicate) |->
         (!rsp_data.deliver && !rsp_data.schedule_forward && !rsp_data.send_now))
      else $error("duplicate arrival raised a forwarding flag");

   // A missing entry never sends and carries no hop count.
   a_missing_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.entry_missing) |->
         (!rsp_data.send_now && rsp_data.hops_out == 8'd0))
      else $error("missing entry produced a send");

endmodule

bind counter_based_flood_filter_core cbff_checker u_cbff_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* bench/tb.sv */
// Self-checking testbench for the counter-based flood duplicate filter core.
`timescale 1ns / 100ps

module tb;
   import cbff_pkg::*;

   localparam int HIST_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 100;
   localparam int NUM_PHASES = 5;
   localparam int MAX_SHOWN = 40;

   // The fourth request kind has no meaning and must leave the filter untouched.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // One row of the directed stimulus table.
   typedef struct {
      cbff_req_type req;
      bit           typed;
      cbff_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   cbff_req_type req_data = '0;
   logic         rsp_valid;
   cbff_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = CSR_MAX_COUNTER;
   logic [15:0]  csr_wdata = '0;

   // Predicted filter state and register copy.
   cbff_entry_type history [HIST_DEPTH];
   int unsigned    hist_oldest;
   int unsigned    hist_fill;
   logic [15:0]    local_seq;
   cbff_cfg_type   cfg;

   cbff_rsp_type   pending_verdicts [$];
   stim_row_type   directed_rows [$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned kind_count [4];
   int unsigned dup_count = 0;
   int unsigned missing_count = 0;
   int unsigned suppressed_count = 0;
   int unsigned eviction_count = 0;

   counter_based_flood_filter_core #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Search the live window of the history, oldest first.
   function automatic int find_slot(input logic [15:0] src, input logic [15:0] seq);
      int unsigned k;
      int unsigned slot;
      for (k = 0; k < hist_fill; k++) begin
         slot = (hist_oldest + k) % HIST_DEPTH;
         if (history[slot].src == src && history[slot].seq == seq) return int'(slot);
      end
      return -1;
   endfunction

   // Count a repeat of a known packet, or enter a new one, evicting the oldest when full.
   function automatic bit record_packet(input logic [15:0] src, input logic [15:0] seq);
      int          hit_slot;
      int unsigned slot;
      hit_slot = find_slot(src, seq);
      if (hit_slot >= 0) begin
         if (history[hit_slot].count < cfg.max_counter)
            history[hit_slot].count = history[hit_slot].count + 8'd1;
         return 1'b1;
      end
      if (hist_fill >= HIST_DEPTH) begin
         slot = hist_oldest;
         hist_oldest = (hist_oldest + 1) % HIST_DEPTH;
         eviction_count++;
      end else begin
         slot = (hist_oldest + hist_fill) % HIST_DEPTH;
         hist_fill++;
      end
      history[slot].src = src;
      history[slot].seq = seq;
      history[slot].count = 8'd0;
      return 1'b0;
   endfunction

   // Work out the filter's verdict for one request and advance the predicted state.
   function automatic cbff_rsp_type filter_verdict(input cbff_req_type r);
      cbff_rsp_type v;
      int           slot;
      v = '0;
      case (r.kind)
         KIND_ORIGINATE: begin
            local_seq = local_seq + 16'd1;
            void'(record_packet(cfg.own_address, local_seq));
            v.send_now = 1'b1;
            v.seq_out = local_seq;
         end
         KIND_ARRIVAL: begin
            v.hops_out = (r.hops_in == 8'hFF) ? 8'hFF : r.hops_in + 8'd1;
            if (record_packet(r.src_addr, r.seq_num)) begin
               v.duplicate = 1'b1;
               dup_count++;
            end else begin
               v.deliver = (r.dst_addr == cfg.own_address) ||
                           (r.dst_addr == cfg.broadcast_address);
               v.schedule_forward = (r.dst_addr != cfg.own_address);
            end
         end
         KIND_FORWARD: begin
            slot = find_slot(r.src_addr, r.seq_num);
            if (slot < 0) begin
               v.entry_missing = 1'b1;
               missing_count++;
            end else if (history[slot].count < cfg.max_counter) begin
               v.send_now = 1'b1;
            end else begin
               suppressed_count++;
            end
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   function automatic cbff_req_type mk_req(input logic [1:0] kind, input logic [15:0] src,
                                           input logic [15:0] seq, input logic [15:0] dst,
                                           input logic [7:0] hops);
      cbff_req_type r;
      r.kind = kind;
      r.src_addr = src;
      r.seq_num = seq;
      r.dst_addr = dst;
      r.hops_in = hops;
      return r;
   endfunction

   function automatic cbff_rsp_type mk_rsp(input logic dup, input logic del, input logic sch,
                                           input logic snd, input logic mis,
                                           input logic [7:0] hops, input logic [15:0] seq);
      cbff_rsp_type v;
      v.duplicate = dup;
      v.deliver = del;
      v.schedule_forward = sch;
      v.send_now = snd;
      v.entry_missing = mis;
      v.hops_out = hops;
      v.seq_out = seq;
      return v;
   endfunction

   task automatic add_row(input cbff_req_type r, input bit typed, input cbff_rsp_type v);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = v;
      directed_rows.push_back(row);
   endtask

   // Present one request and hold it until the core takes it. Start is left high so
   // that the next request can follow without a gap.
   task automatic issue(input cbff_req_type r, input bit typed, input cbff_rsp_type typed_rsp);
      cbff_rsp_type v;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      v = filter_verdict(r);
      pending_verdicts.push_back(typed ? typed_rsp : v);
      kind_count[r.kind]++;
   endtask

   // Stop issuing and wait until every outstanding request has produced its result.
   task automatic drain;
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; valid stays high so that writes can go back to back.
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_COUNTER: cfg.max_counter = val[7:0];
         CSR_OWN_ADDR:    cfg.own_address = val;
         CSR_BCAST_ADDR:  cfg.broadcast_address = val;
         default: begin
         end
      endcase
   endtask

   // Keys are drawn mostly from the live history so that repeats and counter
   // saturation are common; a small pool larger than the FIFO brings back evicted keys.
   task automatic make_item(output cbff_req_type r);
      int unsigned sel;
      int unsigned slot;
      sel = $urandom_range(0, 99);
      r.kind = (sel < 15) ? KIND_ORIGINATE : (sel < 60) ? KIND_ARRIVAL :
               (sel < 93) ? KIND_FORWARD : KIND_UNUSED;
      sel = $urandom_range(0, 99);
      if (sel < 55 && hist_fill > 0) begin
         slot = (hist_oldest + $urandom_range(0, hist_fill - 1)) % HIST_DEPTH;
         r.src_addr = history[slot].src;
         r.seq_num = history[slot].seq;
      end else if (sel < 80) begin
         r.src_addr = 16'($urandom_range(0, 3));
         r.seq_num = 16'($urandom_range(0, 7));
      end else if (sel < 88) begin
         // A packet that a recent or upcoming originate may collide with.
         r.src_addr = cfg.own_address;
         r.seq_num = local_seq + 16'($urandom_range(0, 2));
      end else begin
         r.src_addr = 16'($urandom);
         r.seq_num = 16'($urandom);
      end
      sel = $urandom_range(0, 99);
      r.dst_addr = (sel < 30) ? cfg.own_address : (sel < 60) ? cfg.broadcast_address :
                   16'($urandom);
      sel = $urandom_range(0, 99);
      r.hops_in = (sel < 10) ? 8'hFF : (sel < 15) ? 8'hFE : 8'($urandom);
   endtask

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Compare each result with the oldest outstanding prediction.
   always @(posedge clock) begin
      cbff_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("%0t: result %h with no request outstanding", $time, rsp_data);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data !== want) begin
               error_count++;
               if (error_count <= MAX_SHOWN) begin
                  $display("%0t: expected dup=%b del=%b fwd=%b snd=%b mis=%b hops=%0d seq=%0d",
                           $time, want.duplicate, want.deliver, want.schedule_forward,
                           want.send_now, want.entry_missing, want.hops_out, want.seq_out);
                  $display("%0t:      got dup=%b del=%b fwd=%b snd=%b mis=%b hops=%0d seq=%0d",
                           $time, rsp_data.duplicate, rsp_data.deliver,
                           rsp_data.schedule_forward, rsp_data.send_now,
                           rsp_data.entry_missing, rsp_data.hops_out, rsp_data.seq_out);
               end
            end
         end
      end
   end

   initial begin
      cbff_req_type r;
      int unsigned  phase;
      int unsigned  n;
      int unsigned  gap_pct;
      logic [7:0]   max_val;
      logic [15:0]  own_val;
      logic [15:0]  bcast_val;

      // Predicted state after reset.
      foreach (history[i]) history[i] = '0;
      foreach (kind_count[i]) kind_count[i] = 0;
      hist_oldest = 0;
      hist_fill = 0;
      local_seq = '0;
      cfg.max_counter = MAX_COUNTER_RST;
      cfg.own_address = OWN_ADDR_RST;
      cfg.broadcast_address = BCAST_ADDR_RST;

      // Directed table, run with the reset register values (limit 3, own 0, broadcast all ones).
      // Missing entry on an empty history.
      add_row(mk_req(KIND_FORWARD, 16'h1234, 16'd5, 16'd0, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 16'd0));
      // Fresh broadcast arrival that the first originate will collide with.
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd1, 16'hFFFF, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'd1, 16'd0));
      // First originate takes sequence 1 and bumps that entry's counter.
      add_row(mk_req(KIND_ORIGINATE, 16'h0000, 16'h0000, 16'h0000, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 16'd1));
      add_row(mk_req(KIND_FORWARD, 16'h0000, 16'd1, 16'h0000, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 16'd0));
      // Duplicates push the counter to the limit; hop count saturates.
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd1, 16'h0000, 8'hFF), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 16'd0));
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd1, 16'h0000, 8'hFE), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 16'd0));
      // Counter at the limit: forwarding suppressed.
      add_row(mk_req(KIND_FORWARD, 16'h0000, 16'd1, 16'hFFFF, 8'hFF), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0));
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd1, 16'h5A5A, 8'd7), 1'b1,
              mk_rsp(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd8, 16'd0));
      // Fresh arrival addressed to this node: delivered, not forwarded.
      add_row(mk_req(KIND_ARRIVAL, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'd1, 16'd0));
      // Fresh arrival for another node: forwarded only.
      add_row(mk_req(KIND_ARRIVAL, 16'hAAAA, 16'h5555, 16'h1234, 8'h80), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h81, 16'd0));
      // The unused kind yields an all-zero result and leaves the state alone.
      add_row(mk_req(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 16'd0));
      add_row(mk_req(KIND_FORWARD, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd0), 1'b1,
              mk_rsp(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 16'd0));
      // Remaining rows go through the predictor.
      add_row(mk_req(KIND_ORIGINATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0, '0);
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd2, 16'hFFFF, 8'd3), 1'b0, '0);
      add_row(mk_req(KIND_FORWARD, 16'h0000, 16'd2, 16'h0000, 8'd0), 1'b0, '0);
      add_row(mk_req(KIND_FORWARD, 16'hAAAA, 16'h5555, 16'h0000, 8'd0), 1'b0, '0);
      add_row(mk_req(KIND_ORIGINATE, 16'h0000, 16'h0000, 16'h0000, 8'd0), 1'b0, '0);
      add_row(mk_req(KIND_ARRIVAL, 16'h0000, 16'd3, 16'h0000, 8'd0), 1'b0, '0);
      add_row(mk_req(KIND_UNUSED, 16'h0000, 16'h0000, 16'h0000, 8'd0), 1'b0, '0);

      // Synchronous reset, held before the first request.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
         if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end

      // Random phases, each under its own register setting.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain();
         case (phase)
            0: begin
               max_val = 8'd0;
               own_val = 16'h0000;
               bcast_val = 16'hFFFF;
            end
            1: begin
               max_val = 8'hFF;
               own_val = 16'hFFFF;
               bcast_val = 16'h0000;
            end
            2: begin
               // Own address doubles as broadcast.
               max_val = 8'd1;
               own_val = 16'h1234;
               bcast_val = 16'h1234;
            end
            3: begin
               max_val = 8'($urandom_range(2, 6));
               own_val = 16'($urandom);
               bcast_val = 16'($urandom);
            end
            default: begin
               max_val = 8'($urandom);
               own_val = 16'($urandom);
               bcast_val = 16'($urandom);
            end
         endcase
         // Upper data bits of the counter limit write are don't-care; drive them randomly.
         csr_write(CSR_MAX_COUNTER, {8'($urandom), max_val});
         csr_write(CSR_OWN_ADDR, own_val);
         csr_write(CSR_BCAST_ADDR, bcast_val);
         csr_valid <= 1'b0;

         gap_pct = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Idle pattern changes every 25 requests; the last phase runs flat out.
            if (n % 25 == 0)
               gap_pct = (phase == NUM_PHASES - 1) ? 0 : 30 * $urandom_range(0, 2);
            make_item(r);
            issue(r, 1'b0, '0);
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 13)) @(posedge clock);
            end
         end
      end

      // Let the last results arrive, then allow for the core's worst latency.
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         error_count += pending_verdicts.size();
         $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
      end

      $display("%0d originate, %0d arrival, %0d forward, %0d unused requests over %0d settings.",
               kind_count[KIND_ORIGINATE], kind_count[KIND_ARRIVAL], kind_count[KIND_FORWARD],
               kind_count[KIND_UNUSED], NUM_PHASES + 1);
      $display("Saw %0d duplicates, %0d missing entries, %0d suppressed forwards, %0d evictions.",
               dup_count, missing_count, suppressed_count, eviction_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d errors", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* counter_based_flood_filter_core.f */
hw/rtl/cbff_pkg.sv
hw/rtl/cbff_hist_mem.sv
hw/rtl/cbff_ctrl.sv
hw/rtl/counter_based_flood_filter_core.sv
hw/rtl/cbff_checker.sv
bench/tb.sv
